@@ rtl/core/cminus_token_scanner_defines.svh @@
// Assertion macros used by the checker file of the token scanner.
// Depends on nothing; include it by bare file name where assertions are written.
`ifndef CMINUS_TOKEN_SCANNER_DEFINES_SVH
`define CMINUS_TOKEN_SCANNER_DEFINES_SVH

// General form: clock, active-low reset, property and message given explicitly.
`define CTS_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) else $error(msg);

// Short form for modules whose clock is clk and whose reset is arst_n.
`define CTS_CHECK(lbl, prop, msg) `CTS_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

@@ rtl/core/cts_pkg.sv @@
// Package of the C-minus token scanner: word types, scan modes, token kinds,
// keyword table and character classification. Depends on nothing.
package cts_pkg;

	// Default longest lexeme length before the length saturates.
	localparam int CTS_MAX_LEXEME = 32;

	// Entries of the result queue in front of the token channel.
	localparam int CTS_FIFO_DEPTH = 8;

	// One source character, or the end-of-input mark.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} char_word_t;

	// One recognized token.
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [5:0]  lexeme_length;
		logic        length_overflow;
		logic        last_of_run;
	} token_word_t;

	typedef enum logic [3:0] {
		MODE_START   = 4'd0,
		MODE_ID      = 4'd1,
		MODE_NUM     = 4'd2,
		MODE_SLASH   = 4'd3,
		MODE_COMMENT = 4'd4,
		MODE_STAR    = 4'd5,
		MODE_EQ      = 4'd6,
		MODE_LT      = 4'd7,
		MODE_GT      = 4'd8,
		MODE_BANG    = 4'd9,
		MODE_DONE    = 4'd10
	} scan_mode_t;

	// Token kinds.
	localparam logic [4:0] KIND_ELSE    = 5'd0;
	localparam logic [4:0] KIND_ID      = 5'd6;
	localparam logic [4:0] KIND_NUM     = 5'd7;
	localparam logic [4:0] KIND_ASSIGN  = 5'd8;
	localparam logic [4:0] KIND_EQ      = 5'd9;
	localparam logic [4:0] KIND_NE      = 5'd10;
	localparam logic [4:0] KIND_LT      = 5'd11;
	localparam logic [4:0] KIND_LE      = 5'd12;
	localparam logic [4:0] KIND_GT      = 5'd13;
	localparam logic [4:0] KIND_GE      = 5'd14;
	localparam logic [4:0] KIND_PLUS    = 5'd15;
	localparam logic [4:0] KIND_MINUS   = 5'd16;
	localparam logic [4:0] KIND_TIMES   = 5'd17;
	localparam logic [4:0] KIND_DIV     = 5'd18;
	localparam logic [4:0] KIND_LPAREN  = 5'd19;
	localparam logic [4:0] KIND_RPAREN  = 5'd20;
	localparam logic [4:0] KIND_LBRACK  = 5'd21;
	localparam logic [4:0] KIND_RBRACK  = 5'd22;
	localparam logic [4:0] KIND_LBRACE  = 5'd23;
	localparam logic [4:0] KIND_RBRACE  = 5'd24;
	localparam logic [4:0] KIND_COMMA   = 5'd25;
	localparam logic [4:0] KIND_SEMI    = 5'd26;
	localparam logic [4:0] KIND_UNKNOWN = 5'd27;
	localparam logic [4:0] KIND_END     = 5'd28;

	localparam int KW_COUNT = 6;
	localparam int KW_CHARS = 6;

	// Keyword text, first character in the lowest byte, so the strings read reversed.
	// Order follows the kind codes: else, if, int, return, void, while.
	localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
		{16'h0000, "esle"},
		{32'h0000_0000, "fi"},
		{24'h00_0000, "tni"},
		"nruter",
		{16'h0000, "diov"},
		{8'h00, "elihw"}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd2, 3'd3, 3'd6, 3'd4, 3'd5};

	// What the start state does with one character.
	typedef struct packed {
		scan_mode_t mode;
		logic       emit;
		logic [4:0] kind;
	} start_class_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Keyword kind for a lexeme of at most six characters, else identifier.
	function automatic logic [4:0] kw_kind(input logic [8*KW_CHARS-1:0] prefix,
	                                       input logic [2:0] count);
		logic [4:0] kind;
		logic       same;
		kind = KIND_ID;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			same = (KW_LEN[k] == count);
			for (int i = 0; i < KW_CHARS; i++) begin
				if (i < int'(KW_LEN[k]) && prefix[8*i +: 8] != KW_TEXT[k][8*i +: 8]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				kind = 5'(k);
			end
		end
		return kind;
	endfunction

	// Classification of a character seen in the start state.
	function automatic start_class_t start_class(input logic [7:0] c);
		start_class_t sc;
		sc.mode = MODE_START;
		sc.emit = 1'b1;
		sc.kind = KIND_UNKNOWN;
		if (is_alpha(c)) begin
			sc.mode = MODE_ID;
			sc.emit = 1'b0;
		end else if (is_digit(c)) begin
			sc.mode = MODE_NUM;
			sc.emit = 1'b0;
		end else begin
			case (c)
				8'h0A, 8'h20, 8'h09, 8'h0D: sc.emit = 1'b0;
				"/": begin sc.mode = MODE_SLASH; sc.emit = 1'b0; end
				"=": begin sc.mode = MODE_EQ;    sc.emit = 1'b0; end
				"<": begin sc.mode = MODE_LT;    sc.emit = 1'b0; end
				">": begin sc.mode = MODE_GT;    sc.emit = 1'b0; end
				"!": begin sc.mode = MODE_BANG;  sc.emit = 1'b0; end
				"+": sc.kind = KIND_PLUS;
				"-": sc.kind = KIND_MINUS;
				"*": sc.kind = KIND_TIMES;
				"(": sc.kind = KIND_LPAREN;
				")": sc.kind = KIND_RPAREN;
				"[": sc.kind = KIND_LBRACK;
				"]": sc.kind = KIND_RBRACK;
				"{": sc.kind = KIND_LBRACE;
				"}": sc.kind = KIND_RBRACE;
				",": sc.kind = KIND_COMMA;
				";": sc.kind = KIND_SEMI;
				default: sc.kind = KIND_UNKNOWN;
			endcase
		end
		return sc;
	endfunction

endpackage

@@ rtl/core/cts_stream_ifs.sv @@
// Valid/ready channel interfaces of the token scanner: characters in, tokens out.
// Depends on cts_pkg for the word types.
interface cts_char_if;
	import cts_pkg::*;
	logic       valid;
	logic       ready;
	char_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cts_token_if;
	import cts_pkg::*;
	logic        valid;
	logic        ready;
	token_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/cminus_token_scanner.sv @@
// A character word accepted is held in the input register; the scan step writes its tokens
// into the result queue, and the token channel reads them from there.
// Throughput: one character word per cycle while the result queue has room; the token
// channel moves one word per cycle and a character that causes two tokens takes its share.
// Reset: arst_n clears the scan state, counters and result queue at once; no clearing pass.
// Depends on cts_pkg and the channel interfaces in cts_stream_ifs.sv.
module cminus_token_scanner
	import cts_pkg::*;
#(
	parameter int MAX_LEXEME = CTS_MAX_LEXEME
) (
	input logic         clk,
	input logic         arst_n,
	cts_char_if.sink    chars,
	cts_token_if.source tokens
);

	localparam int LW = $clog2(MAX_LEXEME + 1);
	localparam int PW = $clog2(CTS_FIFO_DEPTH);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	// Scan state.
	scan_mode_t  mode_q, mode_d;
	logic [7:0]  prefix_q [KW_CHARS];
	logic [LW-1:0] cnt_q, cnt_d;
	logic        ovf_q, ovf_d;
	logic [15:0] line_q, line_d, col_q, col_d;
	logic [15:0] tline_q, tline_d, tcol_q, tcol_d;
	logic        done_q, done_d;

	// Result queue.
	token_word_t   fifo_q [CTS_FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	logic in_fire, out_fire;
	logic [PW+1:0] reserve;

	// Room for two tokens of the staged word and two of the next one.
	assign reserve    = (PW+2)'(count_q) + (valid_s1 ? (PW+2)'(2) : '0);
	assign chars.ready = reserve <= (PW+2)'(CTS_FIFO_DEPTH - 2);
	assign in_fire    = chars.valid & chars.ready;
	assign out_fire   = tokens.valid & tokens.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= chars.payload.char_byte;
			eoi_s1  <= chars.payload.end_of_input;
		end
	end

	// Decisions of the scan step.
	start_class_t sc;
	logic end_step, flush, rescan, grow, pair;
	logic alnum, digit;

	assign sc       = start_class(char_s1);
	assign end_step = valid_s1 & (done_q | eoi_s1);
	assign alnum    = is_alpha(char_s1) | is_digit(char_s1);
	assign digit    = is_digit(char_s1);

	// Next scan mode.
	always_comb begin
		mode_d = mode_q;
		flush  = 1'b0;
		rescan = 1'b0;
		grow   = 1'b0;
		pair   = 1'b0;
		if (!valid_s1) begin
			mode_d = mode_q;
		end else if (done_q || eoi_s1) begin
			flush  = !done_q;
			mode_d = MODE_DONE;
		end else begin
			case (mode_q)
				MODE_ID: begin
					if (alnum) grow = 1'b1;
					else begin flush = 1'b1; rescan = 1'b1; end
				end
				MODE_NUM: begin
					if (digit) grow = 1'b1;
					else begin flush = 1'b1; rescan = 1'b1; end
				end
				MODE_EQ, MODE_LT, MODE_GT, MODE_BANG: begin
					if (char_s1 == "=") begin
						pair   = 1'b1;
						mode_d = MODE_START;
					end else begin
						flush  = 1'b1;
						rescan = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (char_s1 == "*") mode_d = MODE_COMMENT;
					else begin flush = 1'b1; rescan = 1'b1; end
				end
				MODE_COMMENT: begin
					if (char_s1 == "*") mode_d = MODE_STAR;
				end
				MODE_STAR: begin
					if (char_s1 == "/") mode_d = MODE_START;
					else if (char_s1 != "*") mode_d = MODE_COMMENT;
				end
				default: rescan = 1'b1;
			endcase
			if (rescan) mode_d = sc.mode;
		end
	end

	// Positions, lexeme length and prefix capture.
	logic          grow_any;
	logic [LW-1:0] base_cnt;
	logic          base_ovf;
	logic          pfx_we;
	logic [2:0]    pfx_idx;

	assign grow_any = grow | (rescan & (sc.mode == MODE_ID || sc.mode == MODE_NUM));
	assign base_cnt = grow ? cnt_q : '0;
	assign base_ovf = grow ? ovf_q : 1'b0;
	assign pfx_we   = grow_any && (base_cnt < LW'(KW_CHARS));
	assign pfx_idx  = base_cnt[2:0];

	always_comb begin
		line_d  = line_q;
		col_d   = col_q;
		tline_d = tline_q;
		tcol_d  = tcol_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		done_d  = done_q | end_step;
		if (valid_s1 && !end_step) begin
			if (char_s1 == 8'h0A) begin
				line_d = sat_inc(line_q);
				col_d  = '0;
			end else begin
				col_d = sat_inc(col_q);
			end
		end
		if (rescan) begin
			tline_d = line_d;
			tcol_d  = col_d;
		end
		if (grow_any) begin
			if (base_cnt < LW'(MAX_LEXEME)) begin
				cnt_d = base_cnt + LW'(1);
				ovf_d = base_ovf;
			end else begin
				cnt_d = base_cnt;
				ovf_d = 1'b1;
			end
		end
	end

	// Tokens of the scan step: a flushed pending token first, then a second one.
	logic [8*KW_CHARS-1:0] prefix_flat;
	logic [LW+5:0]         cnt_wide;
	logic [5:0]            cnt_len;
	logic [4:0]            word_kind;
	logic                  flush_valid, b_valid;
	token_word_t           tok_a, tok_b, res0, res1;
	logic [1:0]            res_n;

	always_comb begin
		for (int i = 0; i < KW_CHARS; i++) begin
			prefix_flat[8*i +: 8] = prefix_q[i];
		end
	end

	assign cnt_wide  = {6'd0, cnt_q};
	assign cnt_len   = cnt_wide[5:0];
	assign word_kind = (ovf_q || cnt_q > LW'(KW_CHARS)) ? KIND_ID
	                   : kw_kind(prefix_flat, cnt_q[2:0]);

	always_comb begin
		tok_a = '{token_kind: KIND_UNKNOWN, start_line: tline_q, start_column: tcol_q,
		          lexeme_length: 6'd1, length_overflow: 1'b0, last_of_run: 1'b0};
		flush_valid = flush;
		case (mode_q)
			MODE_ID: begin
				tok_a.token_kind      = word_kind;
				tok_a.lexeme_length   = cnt_len;
				tok_a.length_overflow = ovf_q;
			end
			MODE_NUM: begin
				tok_a.token_kind      = KIND_NUM;
				tok_a.lexeme_length   = cnt_len;
				tok_a.length_overflow = ovf_q;
			end
			MODE_EQ:    tok_a.token_kind = KIND_ASSIGN;
			MODE_LT:    tok_a.token_kind = KIND_LT;
			MODE_GT:    tok_a.token_kind = KIND_GT;
			MODE_BANG:  tok_a.token_kind = KIND_UNKNOWN;
			MODE_SLASH: tok_a.token_kind = KIND_DIV;
			default:    flush_valid = 1'b0;
		endcase

		tok_b = '{token_kind: sc.kind, start_line: line_d, start_column: col_d,
		          lexeme_length: 6'd1, length_overflow: 1'b0, last_of_run: 1'b1};
		b_valid = end_step | (rescan & sc.emit) | pair;
		if (end_step) begin
			tok_b.token_kind    = KIND_END;
			tok_b.start_line    = line_q;
			tok_b.start_column  = sat_inc(col_q);
			tok_b.lexeme_length = 6'd0;
		end else if (pair) begin
			tok_b.start_line    = tline_q;
			tok_b.start_column  = tcol_q;
			tok_b.lexeme_length = 6'd2;
			case (mode_q)
				MODE_EQ: tok_b.token_kind = KIND_EQ;
				MODE_LT: tok_b.token_kind = KIND_LE;
				MODE_GT: tok_b.token_kind = KIND_GE;
				default: tok_b.token_kind = KIND_NE;
			endcase
		end

		res1 = tok_b;
		if (flush_valid) begin
			res0             = tok_a;
			res0.last_of_run = !b_valid;
			res_n            = b_valid ? 2'd2 : 2'd1;
		end else begin
			res0  = tok_b;
			res_n = {1'b0, b_valid};
		end
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			line_q  <= 16'd1;
			col_q   <= '0;
			tline_q <= 16'd1;
			tcol_q  <= '0;
			done_q  <= 1'b0;
		end else if (valid_s1) begin
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			line_q  <= line_d;
			col_q   <= col_d;
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			done_q  <= done_d;
		end
	end

	// First six lexeme characters for the keyword compare.
	always_ff @(posedge clk) begin
		for (int i = 0; i < KW_CHARS; i++) begin
			if (pfx_we && pfx_idx == 3'(i)) begin
				prefix_q[i] <= char_s1;
			end
		end
	end

	// Result queue: up to two words in, one word out per cycle.
	always_ff @(posedge clk) begin
		if (res_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (res_n == 2'd2) begin
			fifo_q[wr_ptr_q + PW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(res_n);
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(res_n) - (PW+1)'(out_fire);
		end
	end

	assign tokens.valid   = count_q != '0;
	assign tokens.payload = fifo_q[rd_ptr_q];

endmodule

@@ rtl/core/cts_checker.sv @@
// Port-level checks of the token channel of the scanner, attached by bind.
// Depends on cts_pkg and the macros in cminus_token_scanner_defines.svh.
`include "cminus_token_scanner_defines.svh"

module cts_checker
	import cts_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_ready,
	input token_word_t tok_word
);

	// Set once the end token has been taken; from then on only end tokens follow.
	logic end_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_seen_q <= 1'b0;
		end else if (tok_valid && tok_ready && tok_word.token_kind == KIND_END) begin
			end_seen_q <= 1'b1;
		end
	end

	`CTS_CHECK(a_tok_hold, tok_valid && !tok_ready |=> tok_valid && $stable(tok_word), "stalled token word changed")
	`CTS_CHECK(a_kind_range, tok_valid |-> tok_word.token_kind <= KIND_END, "token kind out of range")
	`CTS_CHECK(a_end_shape, tok_valid && tok_word.token_kind == KIND_END |-> tok_word.lexeme_length == 6'd0 && tok_word.last_of_run && !tok_word.length_overflow, "malformed end token")
	`CTS_CHECK(a_end_sticky, end_seen_q && tok_valid |-> tok_word.token_kind == KIND_END, "token after end of input")

endmodule

bind cminus_token_scanner cts_checker u_cts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tokens.valid),
	.tok_ready (tokens.ready),
	.tok_word  (tokens.payload)
);

@@ dv/cminus_token_scanner_tb.sv @@
// Self-checking testbench of cminus_token_scanner: drives character words, predicts tokens.
// Uses cts_pkg types and codes and the channel interfaces of cts_stream_ifs.sv.
// A table of opening characters comes first, then random C-minus text, the end of input and words after it.
module cminus_token_scanner_tb;
	import cts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LEX_LIMIT = CTS_MAX_LEXEME;
	localparam int REPORT_LIMIT = 10;

	// One row of the opening table; pinned rows carry a hand-written token.
	typedef struct packed {
		logic [7:0]  ch;
		logic        pinned;
		token_word_t tok;
	} opening_row_t;

	typedef struct {
		bit          pinned;
		token_word_t tok;
	} hand_check_t;

	localparam opening_row_t OPENING_ROWS [25] = '{
		'{"+",   1'b1, '{KIND_PLUS,    16'd1, 16'd1, 6'd1, 1'b0, 1'b1}},
		'{8'hFF, 1'b1, '{KIND_UNKNOWN, 16'd1, 16'd2, 6'd1, 1'b0, 1'b1}},
		'{8'h00, 1'b1, '{KIND_UNKNOWN, 16'd1, 16'd3, 6'd1, 1'b0, 1'b1}},
		'{"i",   1'b0, '0},
		'{"f",   1'b0, '0},
		'{" ",   1'b0, '0},
		'{"!",   1'b0, '0},
		'{"x",   1'b0, '0},
		'{8'h0A, 1'b0, '0},
		'{"/",   1'b0, '0},
		'{"*",   1'b0, '0},
		'{"*",   1'b0, '0},
		'{"*",   1'b0, '0},
		'{"/",   1'b0, '0},
		'{"<",   1'b0, '0},
		'{"=",   1'b0, '0},
		'{">",   1'b0, '0},
		'{"9",   1'b0, '0},
		'{"/",   1'b0, '0},
		'{"=",   1'b0, '0},
		'{"=",   1'b0, '0},
		'{"!",   1'b0, '0},
		'{"=",   1'b0, '0},
		'{"=",   1'b0, '0},
		'{8'h09, 1'b0, '0}
	};

	string keyword_spelling [6] = '{"else", "if", "int", "return", "void", "while"};
	string operator_spelling [20] = '{"=", "==", "!=", "<", "<=", ">", ">=", "+", "-", "*",
		"/", "(", ")", "[", "]", "{", "}", ",", ";", "!"};

	logic clk = 1'b0;
	logic arst_n;

	cts_char_if  char_ch ();
	cts_token_if tok_ch ();

	cminus_token_scanner i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_ch),
		.tokens (tok_ch)
	);

	// Scanner copy kept by the testbench; reset is applied only once, so it starts here.
	scan_mode_t  lex_mode = MODE_START;
	logic [7:0]  lex_chars [6] = '{default: 8'h00};
	int unsigned lex_len = 0;
	bit          lex_ovf = 1'b0;
	logic [15:0] cur_line = 16'd1;
	logic [15:0] cur_col = 16'd0;
	logic [15:0] tok_line = 16'd1;
	logic [15:0] tok_col = 16'd0;
	bit          at_end = 1'b0;

	token_word_t step_q [$];
	token_word_t tokens_due [$];
	hand_check_t hand_checked_q [$];
	hand_check_t arrived_pin;
	logic [7:0]  src_q [$];

	int idle_pct;
	int stall_pct;
	int hold_cycles;
	int mismatch_count = 0;
	int cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [15:0] bump16(input logic [15:0] v);
		return (&v) ? v : v + 16'd1;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void add_token(input logic [4:0] kind, input logic [15:0] line,
	                                  input logic [15:0] col, input logic [5:0] len,
	                                  input logic ovf);
		step_q.push_back(token_word_t'({kind, line, col, len, ovf, 1'b0}));
	endfunction

	// Only the first six characters are kept; the length stops at the limit.
	function automatic void grow_word(input logic [7:0] c);
		if (lex_len < 6) lex_chars[lex_len] = c;
		if (lex_len < LEX_LIMIT) lex_len++;
		else lex_ovf = 1'b1;
	endfunction

	function automatic logic [4:0] word_code();
		bit same;
		if (lex_ovf || lex_len > 6) return KIND_ID;
		for (int k = 0; k < 6; k++) begin
			same = (keyword_spelling[k].len() == lex_len);
			for (int i = 0; same && i < lex_len; i++) begin
				if (lex_chars[i] != keyword_spelling[k][i]) same = 1'b0;
			end
			if (same) return 5'(k);
		end
		return KIND_ID;
	endfunction

	// Report whatever token is still open and go back to the start state.
	function automatic void close_pending();
		case (lex_mode)
			MODE_ID: add_token(word_code(), tok_line, tok_col, 6'(lex_len), lex_ovf);
			MODE_NUM: add_token(KIND_NUM, tok_line, tok_col, 6'(lex_len), lex_ovf);
			MODE_EQ: add_token(KIND_ASSIGN, tok_line, tok_col, 6'd1, 1'b0);
			MODE_LT: add_token(KIND_LT, tok_line, tok_col, 6'd1, 1'b0);
			MODE_GT: add_token(KIND_GT, tok_line, tok_col, 6'd1, 1'b0);
			MODE_BANG: add_token(KIND_UNKNOWN, tok_line, tok_col, 6'd1, 1'b0);
			MODE_SLASH: add_token(KIND_DIV, tok_line, tok_col, 6'd1, 1'b0);
			default: ;
		endcase
		lex_mode = MODE_START;
	endfunction

	// A character seen from the start state: begins a token or stands alone.
	function automatic void open_token(input logic [7:0] c);
		logic [4:0] kind;
		bit         lone;
		tok_line = cur_line;
		tok_col = cur_col;
		lex_mode = MODE_START;
		lone = 1'b1;
		kind = KIND_UNKNOWN;
		if (is_letter(c) || is_digit_char(c)) begin
			lex_mode = is_letter(c) ? MODE_ID : MODE_NUM;
			lex_len = 0;
			lex_ovf = 1'b0;
			grow_word(c);
			lone = 1'b0;
		end else begin
			case (c)
				8'h20, 8'h09, 8'h0D, 8'h0A: lone = 1'b0;
				"/": begin lex_mode = MODE_SLASH; lone = 1'b0; end
				"=": begin lex_mode = MODE_EQ; lone = 1'b0; end
				"<": begin lex_mode = MODE_LT; lone = 1'b0; end
				">": begin lex_mode = MODE_GT; lone = 1'b0; end
				"!": begin lex_mode = MODE_BANG; lone = 1'b0; end
				"+": kind = KIND_PLUS;
				"-": kind = KIND_MINUS;
				"*": kind = KIND_TIMES;
				"(": kind = KIND_LPAREN;
				")": kind = KIND_RPAREN;
				"[": kind = KIND_LBRACK;
				"]": kind = KIND_RBRACK;
				"{": kind = KIND_LBRACE;
				"}": kind = KIND_RBRACE;
				",": kind = KIND_COMMA;
				";": kind = KIND_SEMI;
				default: kind = KIND_UNKNOWN;
			endcase
		end
		if (lone) add_token(kind, tok_line, tok_col, 6'd1, 1'b0);
	endfunction

	// Tokens caused by one accepted character word, left in step_q.
	function automatic void scan_char(input char_word_t w);
		logic [7:0] c;
		logic [4:0] pair_kind;
		bit         again;
		c = w.char_byte;
		again = 1'b0;
		step_q.delete();
		if (at_end || w.end_of_input) begin
			if (!at_end) close_pending();
			at_end = 1'b1;
			lex_mode = MODE_DONE;
			add_token(KIND_END, cur_line, bump16(cur_col), 6'd0, 1'b0);
		end else begin
			if (c == 8'h0A) begin
				cur_line = bump16(cur_line);
				cur_col = 16'd0;
			end else begin
				cur_col = bump16(cur_col);
			end
			case (lex_mode)
				MODE_ID: begin
					if (is_letter(c) || is_digit_char(c)) grow_word(c);
					else begin close_pending(); again = 1'b1; end
				end
				MODE_NUM: begin
					if (is_digit_char(c)) grow_word(c);
					else begin close_pending(); again = 1'b1; end
				end
				MODE_EQ, MODE_LT, MODE_GT, MODE_BANG: begin
					if (c == "=") begin
						case (lex_mode)
							MODE_EQ: pair_kind = KIND_EQ;
							MODE_LT: pair_kind = KIND_LE;
							MODE_GT: pair_kind = KIND_GE;
							default: pair_kind = KIND_NE;
						endcase
						add_token(pair_kind, tok_line, tok_col, 6'd2, 1'b0);
						lex_mode = MODE_START;
					end else begin
						close_pending();
						again = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (c == "*") lex_mode = MODE_COMMENT;
					else begin close_pending(); again = 1'b1; end
				end
				MODE_COMMENT: begin
					if (c == "*") lex_mode = MODE_STAR;
				end
				MODE_STAR: begin
					if (c == "/") lex_mode = MODE_START;
					else if (c != "*") lex_mode = MODE_COMMENT;
				end
				default: again = 1'b1;
			endcase
			if (again) open_token(c);
		end
		if (step_q.size() > 0) step_q[step_q.size() - 1].last_of_run = 1'b1;
	endfunction

	function automatic void note_mismatch(input string what, input token_word_t e,
	                                      input token_word_t a);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("token mismatch (%s) at cycle %0d: expected kind %0d line %0d col %0d len %0d ovf %0b last %0b, got kind %0d line %0d col %0d len %0d ovf %0b last %0b",
				what, cycle_count, e.token_kind, e.start_line, e.start_column, e.lexeme_length,
				e.length_overflow, e.last_of_run, a.token_kind, a.start_line, a.start_column,
				a.lexeme_length, a.length_overflow, a.last_of_run);
		end
	endfunction

	function automatic void check_token(input token_word_t a);
		token_word_t e;
		string       bad;
		if (tokens_due.size() == 0) begin
			note_mismatch("no token expected", '0, a);
			return;
		end
		e = tokens_due.pop_front();
		bad = "";
		if (a.token_kind != e.token_kind) bad = {bad, " token_kind"};
		if (a.start_line != e.start_line) bad = {bad, " start_line"};
		if (a.start_column != e.start_column) bad = {bad, " start_column"};
		if (a.lexeme_length != e.lexeme_length) bad = {bad, " lexeme_length"};
		if (a.length_overflow != e.length_overflow) bad = {bad, " length_overflow"};
		if (a.last_of_run != e.last_of_run) bad = {bad, " last_of_run"};
		if (bad != "") note_mismatch(bad, e, a);
	endfunction

	// Watch both channels: predict on every accepted character word, check every token word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_ch.valid && char_ch.ready) begin
				arrived_pin = hand_checked_q.pop_front();
				scan_char(char_ch.payload);
				if (arrived_pin.pinned) tokens_due.push_back(arrived_pin.tok);
				else foreach (step_q[i]) tokens_due.push_back(step_q[i]);
			end
			if (tok_ch.valid && tok_ch.ready) check_token(tok_ch.payload);
		end
	end

	// Token sink: random stalls, or a long hold-off counted down here.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			tok_ch.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			tok_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one character word, with random gaps in front, until it is accepted.
	task automatic offer_char(input logic [7:0] c, input bit eoi, input bit pinned,
	                          input token_word_t tok);
		hand_checked_q.push_back('{pinned, tok});
		while ($urandom_range(99) < idle_pct) begin
			char_ch.valid <= 1'b0;
			char_ch.payload <= char_word_t'(9'($urandom_range(511)));
			@(posedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.payload <= '{char_byte: c, end_of_input: eoi};
		@(posedge clk);
		while (!char_ch.ready) @(posedge clk);
	endtask

	task automatic offer_plain(input logic [7:0] c);
		offer_char(c, 1'b0, 1'b0, '0);
	endtask

	// Stop sending and wait until every predicted token word has come back.
	task automatic wait_drained();
		char_ch.valid <= 1'b0;
		@(posedge clk);
		while (tokens_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(3))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0D;
			default: return 8'h0A;
		endcase
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
	endfunction

	// Append one random piece of source text: mostly real tokens, some comments and noise.
	function automatic void build_fragment();
		string text;
		int    len;
		int    pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			text = keyword_spelling[$urandom_range(5)];
			case ($urandom_range(5))
				0: text = {text, "s"};
				1: text = text.substr(0, text.len() - 2);
				2: text = text.toupper();
				default: ;
			endcase
			add_text(text);
		end else if (pick < 30) begin
			len = ($urandom_range(15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
			src_q.push_back(rand_letter());
			for (int i = 1; i < len; i++) begin
				src_q.push_back(($urandom_range(3) == 0) ? rand_digit() : rand_letter());
			end
		end else if (pick < 40) begin
			len = ($urandom_range(15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 5);
			for (int i = 0; i < len; i++) src_q.push_back(rand_digit());
		end else if (pick < 65) begin
			add_text(operator_spelling[$urandom_range(19)]);
		end else if (pick < 75) begin
			src_q.push_back(rand_blank());
		end else if (pick < 82) begin
			add_text("/*");
			repeat ($urandom_range(6)) begin
				case ($urandom_range(5))
					0: src_q.push_back("*");
					1: src_q.push_back("/");
					2: src_q.push_back(8'h0A);
					3: src_q.push_back(8'h20);
					4: src_q.push_back(8'($urandom_range(255)));
					default: src_q.push_back(rand_letter());
				endcase
			end
			case ($urandom_range(2))
				0: add_text("*/");
				1: add_text("**/");
				default: add_text("***/");
			endcase
		end else if (pick < 90) begin
			src_q.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 3)) src_q.push_back(rand_blank());
		end
		if ($urandom_range(1)) src_q.push_back(8'h20);
	endfunction

	task automatic run_random(input int idle, input int stall, input int count,
	                          input bit long_hold);
		int sent;
		idle_pct = idle;
		stall_pct = stall;
		for (sent = 0; sent < count; sent++) begin
			// Hold the sink off long enough for the result queue to fill and stall the input.
			if (long_hold && sent == count / 3) hold_cycles = 200;
			if (src_q.size() == 0) build_fragment();
			offer_plain(src_q.pop_front());
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		char_ch.valid = 1'b0;
		char_ch.payload = '0;
		tok_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Opening table: extremes, every operator mode, comments, rescans.
		foreach (OPENING_ROWS[r]) begin
			offer_char(OPENING_ROWS[r].ch, 1'b0, OPENING_ROWS[r].pinned, OPENING_ROWS[r].tok);
		end
		wait_drained();

		run_random(0, 0, 330, 1'b1);
		run_random(45, 0, 330, 1'b0);
		run_random(0, 45, 330, 1'b0);
		run_random(32, 32, 335, 1'b0);

		// End the input with a pending identifier so the flush and the end token come
		// from one word.
		idle_pct = 0;
		stall_pct = 0;
		add_text("ab;zz");
		while (src_q.size() != 0) offer_plain(src_q.pop_front());
		offer_char(8'($urandom_range(255)), 1'b1, 1'b0, '0);

		// After the end every word gives one more end token, whatever it carries.
		idle_pct = 32;
		stall_pct = 32;
		repeat (6) offer_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
		wait_drained();
		repeat (16) @(posedge clk);

		if (mismatch_count == 0 && tokens_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
